// ----- src/ssd_pkg.sv -----
`timescale 1ns / 1ps

package ssd_pkg;

  // Display geometry
  localparam int DIGIT_COUNT = 4;
  localparam int PHASE_W     = $clog2(DIGIT_COUNT);

  // Request codes carried by an input item
  typedef enum logic [1:0] {
    REQ_SCAN = 2'd0,
    REQ_DEC  = 2'd1,
    REQ_HEX  = 2'd2,
    REQ_TIME = 2'd3
  } req_t;

  // Item leaving the conversion pipeline: decimal path partial results plus
  // the ready-made digits of hex and time loads
  typedef struct packed {
    req_t        req;
    logic [15:0] direct;
    logic [13:0] rem;
    logic [9:0]  q1;
    logic [6:0]  q2;
    logic [3:0]  q3;
  } conv_item_t;

endpackage

// ----- src/ssd_conv.sv -----
`timescale 1ns / 1ps

module ssd_conv import ssd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [31:0] number,
  input  logic        time_mode,
  input  logic [7:0]  hours,
  input  logic [7:0]  minutes,
  input  logic [7:0]  seconds,
  input  logic [9:0]  milliseconds,
  output logic        item_valid,
  output conv_item_t  item,
  input  logic        take
);

  // 16^i mod 10000, used to fold the 32-bit value into a small sum
  localparam logic [13:0] FOLD_W [8] = '{
    14'd1, 14'd16, 14'd256, 14'd4096, 14'd5536, 14'd8576, 14'd7216, 14'd5456
  };

  // x / 10 for x up to 1023
  function automatic logic [6:0] div10(input logic [9:0] x);
    logic [17:0] p;
    begin
      p = 18'(x) * 18'd205;
      return p[17:11];
    end
  endfunction

  // x / 100 for x up to 1023
  function automatic logic [3:0] div100(input logic [9:0] x);
    logic [15:0] p;
    begin
      p = 16'(x) * 16'd41;
      return p[15:12];
    end
  endfunction

  function automatic logic [3:0] units(input logic [9:0] x);
    logic [9:0] d;
    begin
      d = x - 10'(div10(x)) * 10'd10;
      return d[3:0];
    end
  endfunction

  function automatic logic [3:0] tens(input logic [9:0] x);
    logic [6:0] d;
    begin
      d = div10(x) - 7'(div100(x)) * 7'd10;
      return d[3:0];
    end
  endfunction

  // Stage registers
  logic        v0, v1, v2, v3, v4;
  req_t        req0, req1, req2, req3;
  logic [31:0] number0;
  logic        tmode0;
  logic [7:0]  hours0, minutes0, seconds0;
  logic [9:0]  ms0;
  logic [15:0] direct1, direct2, direct3;
  logic [18:0] sum1, sum2;
  logic [5:0]  qest2;
  logic [13:0] rem3;
  conv_item_t  item4;

  logic        free0, free1, free2, free3, free4;
  logic [15:0] direct_a;
  logic [18:0] sum_a;
  logic [32:0] prod_b;
  logic [18:0] sub_c;
  logic [18:0] rem_c;
  logic [29:0] p1_d, p2_d, p3_d;

  // Stall chain: a stage is free when empty or when its item moves on
  always_comb begin
    free4 = !v4 || take;
    free3 = !v3 || free4;
    free2 = !v2 || free3;
    free1 = !v1 || free2;
    free0 = !v0 || free1;
  end

  assign in_ready   = free0;
  assign item_valid = v4;
  assign item       = item4;

  // Stage A: time digits, hex nibbles, and fold of the decimal value
  always_comb begin
    unique case (req0)
      REQ_TIME: begin
        if (tmode0) begin
          direct_a = {tens({2'b00, hours0}), units({2'b00, hours0}),
                      tens({2'b00, minutes0}), units({2'b00, minutes0})};
        end else begin
          direct_a = {units({2'b00, minutes0}), tens({2'b00, seconds0}),
                      units({2'b00, seconds0}), tens(ms0)};
        end
      end
      default: direct_a = number0[15:0];
    endcase
    sum_a = '0;
    for (int i = 0; i < 8; i++) begin
      sum_a = sum_a + 19'(number0[4*i +: 4]) * 19'(FOLD_W[i]);
    end
  end

  // Stage B: estimate of sum / 10000, low by at most one
  assign prod_b = 33'(sum1) * 33'd13421;

  // Stage C: remainder with one correction step
  always_comb begin
    sub_c = sum2 - 19'(qest2) * 19'd10000;
    rem_c = (sub_c >= 19'd10000) ? sub_c - 19'd10000 : sub_c;
  end

  // Stage D: quotients by 10, 100 and 1000
  always_comb begin
    p1_d = 30'(rem3) * 30'd52429;
    p2_d = 30'(rem3) * 30'd5243;
    p3_d = 30'(rem3) * 30'd16778;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (free0) v0 <= in_valid;
      if (free1) v1 <= v0;
      if (free2) v2 <= v1;
      if (free3) v3 <= v2;
      if (free4) v4 <= v3;
    end
  end

  // Payload advance
  always_ff @(posedge clk) begin
    if (free0) begin
      req0     <= req_t'(req_type);
      number0  <= number;
      tmode0   <= time_mode;
      hours0   <= hours;
      minutes0 <= minutes;
      seconds0 <= seconds;
      ms0      <= milliseconds;
    end
    if (free1) begin
      req1    <= req0;
      direct1 <= direct_a;
      sum1    <= sum_a;
    end
    if (free2) begin
      req2    <= req1;
      direct2 <= direct1;
      sum2    <= sum1;
      qest2   <= prod_b[32:27];
    end
    if (free3) begin
      req3    <= req2;
      direct3 <= direct2;
      rem3    <= rem_c[13:0];
    end
    if (free4) begin
      item4.req    <= req3;
      item4.direct <= direct3;
      item4.rem    <= rem3;
      item4.q1     <= p1_d[28:19];
      item4.q2     <= p2_d[25:19];
      item4.q3     <= p3_d[27:24];
    end
  end

`ifndef SYNTHESIS
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (v3 && req3 == REQ_DEC) |-> rem3 < 14'd10000)
    else $error("decimal remainder out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (v4 && !take) |=> (v4 && $stable(item4)))
    else $error("stalled item changed");

  a_input_hold: assert property (@(posedge clk) disable iff (rst)
    (v0 && !free0) |=> (v0 && $stable(number0)))
    else $error("blocked input stage changed");
`endif

endmodule

// ----- src/ssd_scan.sv -----
`timescale 1ns / 1ps

module ssd_scan import ssd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  conv_item_t item,
  output logic       take,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] segment_pattern,
  output logic [3:0] digit_enable_n
);

  // Active-low font, segments a..g in bits 0-6
  function automatic logic [7:0] font(input logic [3:0] nib);
    logic [7:0] f;
    begin
      unique case (nib)
        4'h0: f = 8'hc0;
        4'h1: f = 8'hf9;
        4'h2: f = 8'ha4;
        4'h3: f = 8'hb0;
        4'h4: f = 8'h99;
        4'h5: f = 8'h92;
        4'h6: f = 8'h82;
        4'h7: f = 8'hf8;
        4'h8: f = 8'h80;
        4'h9: f = 8'h90;
        4'ha: f = 8'h88;
        4'hb: f = 8'h83;
        4'hc: f = 8'hc6;
        4'hd: f = 8'ha1;
        4'he: f = 8'h86;
        default: f = 8'h8e;
      endcase
      return f;
    end
  endfunction

  logic [DIGIT_COUNT-1:0]       dp_mask;
  logic                         hex_flag;
  logic [PHASE_W-1:0]           dec_phase, hex_phase;
  logic [DIGIT_COUNT-1:0][3:0]  digits;

  logic                         out_free, is_scan, fire;
  logic [PHASE_W-1:0]           phase_cur, phase_next;
  logic [DIGIT_COUNT-1:0][3:0]  dec_digits;
  logic [13:0]                  d0;
  logic [9:0]                   d1;
  logic [6:0]                   d2;
  logic [3:0]                   nib;
  logic [7:0]                   font_pat;
  logic [7:0]                   seg_next;

  // Handshake toward the pipeline: loads never wait for the output side
  always_comb begin
    out_free = !out_valid || out_ready;
    is_scan  = item.req == REQ_SCAN;
    take     = out_free || !is_scan;
    fire     = item_valid && take;
  end

  // Finish decimal digits from the quotients
  always_comb begin
    d0 = item.rem - 14'(item.q1) * 14'd10;
    d1 = item.q1 - 10'(item.q2) * 10'd10;
    d2 = item.q2 - 7'(item.q3) * 7'd10;
    dec_digits = {item.q3, d2[3:0], d1[3:0], d0[3:0]};
  end

  // Advance the active counter and look up the digit
  always_comb begin
    phase_cur  = hex_flag ? hex_phase : dec_phase;
    phase_next = (phase_cur == PHASE_W'(DIGIT_COUNT - 1)) ? '0 : phase_cur + 1'b1;
    nib        = digits[phase_next];
    font_pat   = font(nib);
    seg_next   = {~dp_mask[phase_next], font_pat[6:0]};
  end

  // Control state and held digits
  always_ff @(posedge clk) begin
    if (rst) begin
      dp_mask   <= '0;
      hex_flag  <= 1'b0;
      dec_phase <= '0;
      hex_phase <= '0;
      digits    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) dp_mask <= cfg_wdata;
      if (out_free) out_valid <= fire && is_scan;
      if (fire) begin
        unique case (item.req)
          REQ_SCAN: begin
            if (hex_flag) hex_phase <= phase_next;
            else dec_phase <= phase_next;
          end
          REQ_DEC: begin
            hex_flag <= 1'b0;
            digits   <= dec_digits;
          end
          REQ_HEX: begin
            hex_flag <= 1'b1;
            digits   <= item.direct;
          end
          REQ_TIME: begin
            hex_flag <= 1'b0;
            digits   <= item.direct;
          end
        endcase
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (fire && is_scan) begin
      segment_pattern <= seg_next;
      digit_enable_n  <= ~(DIGIT_COUNT'(1) << phase_next);
    end
  end

`ifndef SYNTHESIS
  a_enable_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(~digit_enable_n))
    else $error("digit enable not one-hot");

  a_bcd_digits: assert property (@(posedge clk) disable iff (rst)
    !hex_flag |-> (digits[0] <= 4'd9 && digits[1] <= 4'd9 &&
                   digits[2] <= 4'd9 && digits[3] <= 4'd9))
    else $error("decimal digit out of range");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (fire && !is_scan && !out_valid) |=> !out_valid)
    else $error("load produced a result");
`endif

endmodule

// ----- src/seven_segment_scan_driver.sv -----
`timescale 1ns / 1ps

// Channel   Handshake                Payload
// in        in_valid / in_ready      req_type, number, time_mode, hours, minutes,
//                                    seconds, milliseconds
// out       out_valid / out_ready    segment_pattern, digit_enable_n
// cfg       cfg_we                   cfg_wdata (dp_mask)
//
// One item per cycle is accepted while in_ready is high; a scan tick's result passes through
// the input register, four conversion stages and the result register.
// Loads travel the same pipeline in order and update the held digits at its end.
// Reset clears the held value, mode, both digit counters and the dp mask.
// A stalled output fills the pipeline; in_ready drops only when every stage holds an item.

module seven_segment_scan_driver import ssd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [31:0] number,
  input  logic        time_mode,
  input  logic [7:0]  hours,
  input  logic [7:0]  minutes,
  input  logic [7:0]  seconds,
  input  logic [9:0]  milliseconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  segment_pattern,
  output logic [3:0]  digit_enable_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata
);

  logic       item_valid;
  conv_item_t item;
  logic       take;

  // Digit conversion pipeline
  ssd_conv u_conv (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .number       (number),
    .time_mode    (time_mode),
    .hours        (hours),
    .minutes      (minutes),
    .seconds      (seconds),
    .milliseconds (milliseconds),
    .item_valid   (item_valid),
    .item         (item),
    .take         (take)
  );

  // Held digits, scan counters and result register
  ssd_scan u_scan (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item            (item),
    .take            (take),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .segment_pattern (segment_pattern),
    .digit_enable_n  (digit_enable_n)
  );

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import ssd_pkg::*;

  localparam int LATENCY    = 6;
  localparam int PHASE_ITEMS = 100;
  localparam int NUM_PHASES = 8;

  // One request as it crosses the input channel
  typedef struct packed {
    req_t        req;
    logic [31:0] number;
    logic        time_mode;
    logic [7:0]  hours;
    logic [7:0]  minutes;
    logic [7:0]  seconds;
    logic [9:0]  milliseconds;
  } disp_req_t;

  // One lit digit as it leaves the output channel
  typedef struct packed {
    logic [7:0] segments;
    logic [3:0] enables_n;
  } lit_digit_t;

  // Directed row: request plus an optional hand-written result
  typedef struct packed {
    disp_req_t  item;
    logic       typed;
    lit_digit_t lit;
  } directed_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  req_type;
  logic [31:0] number;
  logic        time_mode;
  logic [7:0]  hours;
  logic [7:0]  minutes;
  logic [7:0]  seconds;
  logic [9:0]  milliseconds;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  segment_pattern;
  logic [3:0]  digit_enable_n;
  logic        cfg_we;
  logic [3:0]  cfg_wdata;

  // Shadow display state
  logic [31:0] shown_value = '0;
  logic        shown_hex   = 1'b0;
  logic [1:0]  dec_cursor  = '0;
  logic [1:0]  hex_cursor  = '0;
  logic [3:0]  dp_bits     = '0;

  lit_digit_t    lit_queue[$];
  directed_row_t directed_rows[$];
  int            mismatch_count = 0;
  int            idle_pct = 0;
  int            stall_pct = 0;

  logic [7:0] seg_font [16] = '{
    8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8,
    8'h80, 8'h90, 8'h88, 8'h83, 8'hc6, 8'ha1, 8'h86, 8'h8e
  };

  seven_segment_scan_driver DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .req_type        (req_type),
    .number          (number),
    .time_mode       (time_mode),
    .hours           (hours),
    .minutes         (minutes),
    .seconds         (seconds),
    .milliseconds    (milliseconds),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .segment_pattern (segment_pattern),
    .digit_enable_n  (digit_enable_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Update the shadow display for one request; return 1 when a digit is lit
  function automatic logic advance_display(input disp_req_t it, output lit_digit_t lit);
    logic [1:0]  cursor;
    logic [3:0]  digit;
    logic [31:0] weight;
    lit = '0;
    case (it.req)
      REQ_DEC: begin
        shown_hex   = 1'b0;
        shown_value = it.number;
        return 1'b0;
      end
      REQ_HEX: begin
        shown_hex   = 1'b1;
        shown_value = it.number;
        return 1'b0;
      end
      REQ_TIME: begin
        if (it.time_mode == 1'b0) begin
          shown_value = (it.minutes % 10) * 1000 + ((it.seconds / 10) % 10) * 100
                      + (it.seconds % 10) * 10 + ((it.milliseconds / 10) % 10);
        end else begin
          shown_value = ((it.hours / 10) % 10) * 1000 + (it.hours % 10) * 100
                      + ((it.minutes / 10) % 10) * 10 + (it.minutes % 10);
        end
        shown_hex = 1'b0;
        return 1'b0;
      end
      default: begin
        // Advance the active counter before use
        if (shown_hex) begin
          hex_cursor = hex_cursor + 2'd1;
          cursor     = hex_cursor;
          digit      = shown_value[4*cursor +: 4];
        end else begin
          dec_cursor = dec_cursor + 2'd1;
          cursor     = dec_cursor;
          case (cursor)
            2'd0:    weight = 32'd1;
            2'd1:    weight = 32'd10;
            2'd2:    weight = 32'd100;
            default: weight = 32'd1000;
          endcase
          digit = 4'((shown_value / weight) % 10);
        end
        lit.segments     = seg_font[digit];
        lit.segments[7]  = ~dp_bits[cursor];
        lit.enables_n    = ~(4'b0001 << cursor);
        return 1'b1;
      end
    endcase
  endfunction

  // Present one item, hold it until taken, then record its expected digit
  task automatic send_item(input disp_req_t it, input logic typed, input lit_digit_t typed_lit);
    lit_digit_t lit;
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    req_type     = it.req;
    number       = it.number;
    time_mode    = it.time_mode;
    hours        = it.hours;
    minutes      = it.minutes;
    seconds      = it.seconds;
    milliseconds = it.milliseconds;
    do @(posedge clk); while (!in_ready);
    if (advance_display(it, lit))
      lit_queue.push_back(typed ? typed_lit : lit);
    @(negedge clk);
  endtask

  // Write the dp mask once the pipeline has drained
  task automatic write_dp_mask(input logic [3:0] value);
    in_valid = 1'b0;
    while (lit_queue.size() != 0) @(posedge clk);
    repeat (2 * LATENCY + 4) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we  = 1'b0;
    dp_bits = value;
  endtask

  function automatic void add_row(input req_t req, input logic [31:0] num, input logic mode,
                                  input logic [7:0] h, input logic [7:0] m, input logic [7:0] s,
                                  input logic [9:0] ms, input logic typed,
                                  input logic [7:0] seg, input logic [3:0] en);
    directed_row_t row;
    row.item  = '{req, num, mode, h, m, s, ms};
    row.typed = typed;
    row.lit   = '{seg, en};
    directed_rows.push_back(row);
  endfunction

  function automatic disp_req_t random_item();
    disp_req_t  it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50)      it.req = REQ_SCAN;
    else if (pick < 70) it.req = REQ_DEC;
    else if (pick < 85) it.req = REQ_HEX;
    else                it.req = REQ_TIME;
    case ($urandom_range(3))
      0:       it.number = $urandom();
      1:       it.number = $urandom_range(9999);
      2:       it.number = $urandom_range(99999);
      default: it.number = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
    endcase
    it.time_mode = 1'($urandom_range(1));
    if ($urandom_range(1)) begin
      it.hours        = 8'($urandom_range(23));
      it.minutes      = 8'($urandom_range(59));
      it.seconds      = 8'($urandom_range(59));
      it.milliseconds = 10'($urandom_range(999));
    end else begin
      it.hours        = 8'($urandom_range(255));
      it.minutes      = 8'($urandom_range(255));
      it.seconds      = 8'($urandom_range(255));
      it.milliseconds = 10'($urandom_range(1023));
    end
    return it;
  endfunction

  task automatic note_mismatch(input string what, input logic [7:0] want, input logic [7:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
  endtask

  // Drop the receiver's ready at random
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= stall_pct);
  end

  // Compare each taken digit against the oldest expectation
  always @(posedge clk) begin
    lit_digit_t want;
    if (!rst && out_valid && out_ready) begin
      if (lit_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected item: seg %h en %b", $realtime, segment_pattern,
                   digit_enable_n);
      end else begin
        want = lit_queue.pop_front();
        if (segment_pattern !== want.segments)
          note_mismatch("segment_pattern", want.segments, segment_pattern);
        if (digit_enable_n !== want.enables_n)
          note_mismatch("digit_enable_n", {4'h0, want.enables_n}, {4'h0, digit_enable_n});
      end
    end
  end

  // Stop a hung run
  initial begin
    #500000;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    logic [3:0] dp_plan [NUM_PHASES];
    in_valid     = 1'b0;
    req_type     = REQ_SCAN;
    number       = '0;
    time_mode    = 1'b0;
    hours        = '0;
    minutes      = '0;
    seconds      = '0;
    milliseconds = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    rst          = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset state, extreme values and the font entries for digits 0, 2, 5, 7 and 9
    add_row(REQ_SCAN, 32'h0, 1'b0, 8'd0, 8'd0, 8'd0, 10'd0, 1'b1, 8'hc0, 4'b1101);
    add_row(REQ_SCAN, 32'h0, 1'b0, 8'd0, 8'd0, 8'd0, 10'd0, 1'b1, 8'hc0, 4'b1011);
    add_row(REQ_SCAN, 32'h0, 1'b0, 8'd0, 8'd0, 8'd0, 10'd0, 1'b1, 8'hc0, 4'b0111);
    add_row(REQ_SCAN, 32'h0, 1'b0, 8'd0, 8'd0, 8'd0, 10'd0, 1'b1, 8'hc0, 4'b1110);
    add_row(REQ_DEC, 32'hFFFF_FFFF, 1'b0, 8'd0, 8'd0, 8'd0, 10'd0, 1'b0, 8'h0, 4'h0);
    add_row(REQ_SCAN, 32'h0, 1'b0, 8'd0, 8'd0, 8'd0, 10'd0, 1'b1, 8'h90, 4'b1101);
    add_row(REQ_SCAN, 32'h0, 1'b0, 8'd0, 8'd0, 8'd0, 10'd0, 1'b1, 8'ha4, 4'b1011);
    add_row(REQ_SCAN, 32'h0, 1'b0, 8'd0, 8'd0, 8'd0, 10'd0, 1'b1, 8'hf8, 4'b0111);
    add_row(REQ_SCAN, 32'h0, 1'b0, 8'd0, 8'd0, 8'd0, 10'd0, 1'b1, 8'h92, 4'b1110);
    // Hex letters; upper nibbles never shown
    add_row(REQ_HEX, 32'h1234_FEDC, 1'b0, 8'd0, 8'd0, 8'd0, 10'd0, 1'b0, 8'h0, 4'h0);
    add_row(REQ_SCAN, 32'h0, 1'b0, 8'd0, 8'd0, 8'd0, 10'd0, 1'b1, 8'ha1, 4'b1101);
    add_row(REQ_SCAN, 32'h0, 1'b0, 8'd0, 8'd0, 8'd0, 10'd0, 1'b1, 8'h86, 4'b1011);
    add_row(REQ_SCAN, 32'h0, 1'b0, 8'd0, 8'd0, 8'd0, 10'd0, 1'b1, 8'h8e, 4'b0111);
    add_row(REQ_SCAN, 32'h0, 1'b0, 8'd0, 8'd0, 8'd0, 10'd0, 1'b1, 8'hc6, 4'b1110);
    // Stopwatch load with every time field out of range
    add_row(REQ_TIME, 32'h0, 1'b0, 8'hFF, 8'hFF, 8'hFF, 10'h3FF, 1'b0, 8'h0, 4'h0);
    add_row(REQ_SCAN, 32'h0, 1'b0, 8'd0, 8'd0, 8'd0, 10'd0, 1'b0, 8'h0, 4'h0);
    add_row(REQ_SCAN, 32'h0, 1'b0, 8'd0, 8'd0, 8'd0, 10'd0, 1'b0, 8'h0, 4'h0);
    // Clock load; decimal counter carries on from before
    add_row(REQ_TIME, 32'h0, 1'b1, 8'd23, 8'd59, 8'd0, 10'd0, 1'b0, 8'h0, 4'h0);
    add_row(REQ_SCAN, 32'h0, 1'b0, 8'd0, 8'd0, 8'd0, 10'd0, 1'b0, 8'h0, 4'h0);
    add_row(REQ_SCAN, 32'h0, 1'b0, 8'd0, 8'd0, 8'd0, 10'd0, 1'b0, 8'h0, 4'h0);
    // Hex counter kept apart from the decimal one
    add_row(REQ_HEX, 32'h0000_BA98, 1'b0, 8'd0, 8'd0, 8'd0, 10'd0, 1'b0, 8'h0, 4'h0);
    add_row(REQ_SCAN, 32'h0, 1'b0, 8'd0, 8'd0, 8'd0, 10'd0, 1'b0, 8'h0, 4'h0);
    add_row(REQ_DEC, 32'd1234567890, 1'b0, 8'd0, 8'd0, 8'd0, 10'd0, 1'b0, 8'h0, 4'h0);
    add_row(REQ_SCAN, 32'h0, 1'b0, 8'd0, 8'd0, 8'd0, 10'd0, 1'b0, 8'h0, 4'h0);
    add_row(REQ_SCAN, 32'h0, 1'b0, 8'd0, 8'd0, 8'd0, 10'd0, 1'b0, 8'h0, 4'h0);

    // Walk the directed table with no idling
    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].lit);

    // Random phases: mask setting and the idle and stall rates change per phase
    dp_plan = '{4'hF, 4'h0, 4'h5, 4'hA, 4'(($urandom_range(15))), 4'hF,
                4'(($urandom_range(15))), 4'h0};
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_dp_mask(dp_plan[p]);
      case (p % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 76; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      repeat (PHASE_ITEMS) send_item(random_item(), 1'b0, '0);
    end

    // Drain and let the pipeline settle
    in_valid = 1'b0;
    while (lit_queue.size() != 0) @(posedge clk);
    repeat (4 * LATENCY) @(posedge clk);
    if (mismatch_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
